>>> src/fpr_pkg.sv
// Package: shared types and constants for the framed packet receiver.
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int ByteW  = 8;
  localparam int IndexW = 9;
  localparam int KindW  = 2;
  localparam int CauseW = 2;
  localparam int OutDataW = 24;

  localparam logic [ByteW-1:0] PreambleByte = 8'hFE;
  localparam logic [ByteW-1:0] HeadByte     = 8'h68;
  localparam logic [ByteW-1:0] TailByte     = 8'h16;

  // Body positions before the data bytes
  localparam logic [IndexW-1:0] IdxAddr    = 9'd0;
  localparam logic [IndexW-1:0] IdxCmd     = 9'd1;
  localparam logic [IndexW-1:0] IdxLen     = 9'd2;
  localparam logic [IndexW-1:0] IdxDataBase = 9'd3;

  typedef enum logic [KindW-1:0] {
    KIND_NONE   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [CauseW-1:0] {
    CAUSE_NONE = 2'd0,
    CAUSE_HEAD = 2'd1,
    CAUSE_SUM  = 2'd2,
    CAUSE_TAIL = 2'd3
  } cause_t;

  typedef struct packed {
    kind_t             kind;
    logic [IndexW-1:0] field_index;
    logic [ByteW-1:0]  field_value;
    cause_t            error_cause;
  } result_t;

endpackage

>>> src/fpr_in_stage.sv
// Input register stage: holds one received byte until the parser takes it.
`timescale 1ns / 1ps

module fpr_in_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [fpr_pkg::ByteW-1:0] in_byte,
  input  logic                    advance,
  output logic                    held_valid,
  output logic [fpr_pkg::ByteW-1:0] held_byte
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

endmodule

>>> src/fpr_parser.sv
// Frame parser: phase tracking, checksum and per-byte result.
`timescale 1ns / 1ps

module fpr_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [fpr_pkg::ByteW-1:0] rx_byte,
  output fpr_pkg::result_t          result
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_ADDR,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_TAIL
  } phase_t;

  phase_t                    phase, phase_next;
  logic [fpr_pkg::ByteW-1:0] running_sum, running_sum_next;
  logic [fpr_pkg::ByteW-1:0] data_length, data_length_next;
  logic [fpr_pkg::ByteW-1:0] data_count, data_count_next;
  logic [fpr_pkg::ByteW-1:0] sum_add;
  logic [fpr_pkg::ByteW-1:0] count_inc;

  assign sum_add   = running_sum + rx_byte;
  assign count_inc = data_count + 8'd1;

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    data_length_next = data_length;
    data_count_next  = data_count;
    result.kind        = fpr_pkg::KIND_NONE;
    result.field_index = '0;
    result.field_value = '0;
    result.error_cause = fpr_pkg::CAUSE_NONE;
    unique case (phase)
      PH_PRE: begin
        if (rx_byte == fpr_pkg::HeadByte) begin
          running_sum_next = fpr_pkg::HeadByte;
          phase_next       = PH_ADDR;
        end else if (rx_byte != fpr_pkg::PreambleByte) begin
          phase_next         = PH_IDLE;
          result.kind        = fpr_pkg::KIND_REJECT;
          result.error_cause = fpr_pkg::CAUSE_HEAD;
        end
      end
      PH_ADDR: begin
        running_sum_next   = sum_add;
        phase_next         = PH_CMD;
        result.kind        = fpr_pkg::KIND_FIELD;
        result.field_index = fpr_pkg::IdxAddr;
        result.field_value = rx_byte;
      end
      PH_CMD: begin
        running_sum_next   = sum_add;
        phase_next         = PH_LEN;
        result.kind        = fpr_pkg::KIND_FIELD;
        result.field_index = fpr_pkg::IdxCmd;
        result.field_value = rx_byte;
      end
      PH_LEN: begin
        running_sum_next   = sum_add;
        data_length_next   = rx_byte;
        data_count_next    = '0;
        phase_next         = (rx_byte == '0) ? PH_SUM : PH_DATA;
        result.kind        = fpr_pkg::KIND_FIELD;
        result.field_index = fpr_pkg::IdxLen;
        result.field_value = rx_byte;
      end
      PH_DATA: begin
        running_sum_next   = sum_add;
        data_count_next    = count_inc;
        result.kind        = fpr_pkg::KIND_FIELD;
        result.field_index = fpr_pkg::IdxDataBase + {1'b0, data_count};
        result.field_value = rx_byte;
        if (count_inc >= data_length) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        if (rx_byte == running_sum) begin
          phase_next = PH_TAIL;
        end else begin
          phase_next         = PH_IDLE;
          result.kind        = fpr_pkg::KIND_REJECT;
          result.error_cause = fpr_pkg::CAUSE_SUM;
        end
      end
      PH_TAIL: begin
        phase_next = PH_IDLE;
        if (rx_byte == fpr_pkg::TailByte) begin
          result.kind = fpr_pkg::KIND_ACCEPT;
        end else begin
          result.kind        = fpr_pkg::KIND_REJECT;
          result.error_cause = fpr_pkg::CAUSE_TAIL;
        end
      end
      PH_IDLE: begin
        phase_next = (rx_byte == fpr_pkg::PreambleByte) ? PH_PRE : PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      running_sum <= '0;
      data_length <= '0;
      data_count  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      data_length <= data_length_next;
      data_count  <= data_count_next;
    end
  end

endmodule

>>> src/fpr_out_stage.sv
// Output register stage: holds one result transaction until taken.
`timescale 1ns / 1ps

module fpr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  fpr_pkg::result_t result,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output fpr_pkg::result_t out_result
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= result;
    end
  end

endmodule

>>> src/framed_packet_receiver_unit.sv
// Top level: framed packet receiver, one received byte in, one result out.
//
//  channel  | dir | tdata                               | tuser
//  s_axis   | in  | [7:0] rx_byte                       | -
//  m_axis   | out | [8:0] field_index, [16:9] field_value,| [1:0] kind
//           |     | [18:17] error_cause, [23:19] zero   |
//
// One byte per cycle while m_axis_tready allows it; each byte passes the input
// register, one parser step (state update plus an 8-bit add) and the output
// register, which holds its result until it is taken.
// Reset puts the parser in idle with checksum, length and count cleared.
// A stalled output holds its result; both stages fill before s_axis_tready drops.
`timescale 1ns / 1ps

module framed_packet_receiver_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [fpr_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [8:0] field_index, [16:9] field_value, [18:17] error_cause, [23:19] zero
  output logic [fpr_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [fpr_pkg::KindW-1:0]    m_axis_tuser    // [1:0] kind
);

  logic                      advance;
  logic                      held_valid;
  logic [fpr_pkg::ByteW-1:0] held_byte;
  logic                      step;
  fpr_pkg::result_t          result;
  fpr_pkg::result_t          out_result;

  assign step = held_valid && advance;

  fpr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  fpr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (held_byte),
    .result  (result)
  );

  fpr_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .result     (result),
    .advance    (advance),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result)
  );

  assign m_axis_tuser = out_result.kind;
  assign m_axis_tdata = {5'd0, out_result.error_cause, out_result.field_value,
                         out_result.field_index};

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register empty");

  a_field_only_body: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != fpr_pkg::KIND_FIELD) |->
      (m_axis_tdata[16:0] == 17'd0))
    else $error("index or value set outside a body byte");

  a_cause_on_reject: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tuser == fpr_pkg::KIND_REJECT) == (m_axis_tdata[18:17] != 2'd0)))
    else $error("error cause does not match reject kind");

endmodule

>>> verif/testbench.sv
// Testbench for framed_packet_receiver_unit: random framed byte streams checked against a predictor.
`timescale 1ns / 1ps

module testbench;

  typedef enum logic [3:0] {
    PH_IDLE, PH_PRE, PH_ADDR, PH_CMD, PH_LEN, PH_DATA, PH_SUM, PH_TAIL
  } parse_phase_t;

  typedef enum int {FAULT_NONE, FAULT_HEAD, FAULT_SUM, FAULT_TAIL, FAULT_CUT} frame_fault_t;

  class frame_result_checker;
    parse_phase_t phase;
    logic [fpr_pkg::ByteW-1:0] running_sum;
    logic [fpr_pkg::ByteW-1:0] data_length;
    logic [fpr_pkg::ByteW-1:0] data_count;
    fpr_pkg::result_t expected_results[$];
    int errors, n_checked, n_fields, n_accepted, n_rejected;

    function new();
      phase = PH_IDLE;
      running_sum = '0;
      data_length = '0;
      data_count = '0;
    endfunction

    function fpr_pkg::result_t parse_step(logic [fpr_pkg::ByteW-1:0] rx);
      fpr_pkg::result_t r;
      r.kind = fpr_pkg::KIND_NONE;
      r.field_index = '0;
      r.field_value = '0;
      r.error_cause = fpr_pkg::CAUSE_NONE;
      case (phase)
        PH_PRE: begin
          if (rx == fpr_pkg::HeadByte) begin
            running_sum = fpr_pkg::HeadByte;
            phase = PH_ADDR;
          end else if (rx != fpr_pkg::PreambleByte) begin
            phase = PH_IDLE;
            r.kind = fpr_pkg::KIND_REJECT;
            r.error_cause = fpr_pkg::CAUSE_HEAD;
          end
        end
        PH_ADDR: begin
          running_sum += rx;
          phase = PH_CMD;
          r.kind = fpr_pkg::KIND_FIELD;
          r.field_index = fpr_pkg::IdxAddr;
          r.field_value = rx;
        end
        PH_CMD: begin
          running_sum += rx;
          phase = PH_LEN;
          r.kind = fpr_pkg::KIND_FIELD;
          r.field_index = fpr_pkg::IdxCmd;
          r.field_value = rx;
        end
        PH_LEN: begin
          running_sum += rx;
          data_length = rx;
          data_count = '0;
          phase = (rx == 0) ? PH_SUM : PH_DATA;
          r.kind = fpr_pkg::KIND_FIELD;
          r.field_index = fpr_pkg::IdxLen;
          r.field_value = rx;
        end
        PH_DATA: begin
          running_sum += rx;
          r.kind = fpr_pkg::KIND_FIELD;
          r.field_index = fpr_pkg::IdxDataBase + fpr_pkg::IndexW'(data_count);
          r.field_value = rx;
          data_count += 1'b1;
          if (data_count >= data_length) phase = PH_SUM;
        end
        PH_SUM: begin
          if (rx == running_sum) begin
            phase = PH_TAIL;
          end else begin
            phase = PH_IDLE;
            r.kind = fpr_pkg::KIND_REJECT;
            r.error_cause = fpr_pkg::CAUSE_SUM;
          end
        end
        PH_TAIL: begin
          phase = PH_IDLE;
          if (rx == fpr_pkg::TailByte) begin
            r.kind = fpr_pkg::KIND_ACCEPT;
          end else begin
            r.kind = fpr_pkg::KIND_REJECT;
            r.error_cause = fpr_pkg::CAUSE_TAIL;
          end
        end
        default: begin
          phase = (rx == fpr_pkg::PreambleByte) ? PH_PRE : PH_IDLE;
        end
      endcase
      return r;
    endfunction

    function void note_byte(logic [fpr_pkg::ByteW-1:0] rx);
      expected_results.push_back(parse_step(rx));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(string line);
      $display("[%0t] MISMATCH: %s", $realtime, line);
      errors++;
    endtask

    task check_result(logic [fpr_pkg::OutDataW-1:0] tdata, logic [fpr_pkg::KindW-1:0] tuser);
      fpr_pkg::result_t want;
      logic [fpr_pkg::IndexW-1:0] got_index;
      logic [fpr_pkg::ByteW-1:0] got_value;
      logic [fpr_pkg::CauseW-1:0] got_cause;
      logic [fpr_pkg::OutDataW-fpr_pkg::IndexW-fpr_pkg::ByteW-fpr_pkg::CauseW-1:0] got_pad;
      got_index = tdata[fpr_pkg::IndexW-1:0];
      got_value = tdata[fpr_pkg::IndexW+fpr_pkg::ByteW-1:fpr_pkg::IndexW];
      got_cause = tdata[fpr_pkg::IndexW+fpr_pkg::ByteW+fpr_pkg::CauseW-1:
                        fpr_pkg::IndexW+fpr_pkg::ByteW];
      got_pad = tdata[fpr_pkg::OutDataW-1:fpr_pkg::IndexW+fpr_pkg::ByteW+fpr_pkg::CauseW];
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind=%0d tdata=0x%06h", tuser, tdata));
        return;
      end
      want = expected_results.pop_front();
      n_checked++;
      case (want.kind)
        fpr_pkg::KIND_FIELD: n_fields++;
        fpr_pkg::KIND_ACCEPT: n_accepted++;
        fpr_pkg::KIND_REJECT: n_rejected++;
        default: ;
      endcase
      if (tuser !== want.kind)
        report($sformatf("kind got %0d expected %0d", tuser, want.kind));
      if (got_index !== want.field_index)
        report($sformatf("field_index got %0d expected %0d", got_index, want.field_index));
      if (got_value !== want.field_value)
        report($sformatf("field_value got 0x%02h expected 0x%02h", got_value,
                         want.field_value));
      if (got_cause !== want.error_cause)
        report($sformatf("error_cause got %0d expected %0d", got_cause, want.error_cause));
      if (got_pad !== '0)
        report($sformatf("tdata pad bits got 0x%0h expected 0", got_pad));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [fpr_pkg::ByteW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [fpr_pkg::OutDataW-1:0] m_axis_tdata;
  logic [fpr_pkg::KindW-1:0] m_axis_tuser;

  frame_result_checker rx_model = new();

  int burst_left = 0;
  bit gapless = 1'b0;
  bit hold_off_req = 1'b0;
  int long_holds = 0;
  int bytes_sent = 0;
  int frames_sent = 0;

  framed_packet_receiver_unit DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      rx_model.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Output side: segments of always-ready, random and mostly-stalled, plus one long hold
  initial begin
    int seg_left;
    int ready_mode;
    seg_left = 0;
    ready_mode = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk);
        long_holds++;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 120);
          ready_mode = $urandom_range(0, 2);
        end
        seg_left--;
        case (ready_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #400000;
    $display("Timeout with %0d results outstanding", rx_model.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [fpr_pkg::ByteW-1:0] byte_other_than(
      logic [fpr_pkg::ByteW-1:0] a, logic [fpr_pkg::ByteW-1:0] b);
    logic [fpr_pkg::ByteW-1:0] v;
    do v = $urandom; while (v == a || v == b);
    return v;
  endfunction

  task automatic send_byte(input logic [fpr_pkg::ByteW-1:0] rx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (gapless || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rx;
    do @(posedge clk); while (!s_axis_tready);
    rx_model.note_byte(rx);
    bytes_sent++;
  endtask

  task automatic send_frame(input int n_pre, input logic [fpr_pkg::ByteW-1:0] addr,
                            input logic [fpr_pkg::ByteW-1:0] cmd,
                            input logic [fpr_pkg::ByteW-1:0] len,
                            input frame_fault_t fault);
    logic [fpr_pkg::ByteW-1:0] sum;
    logic [fpr_pkg::ByteW-1:0] d;
    int keep;
    frames_sent++;
    repeat (n_pre) send_byte(fpr_pkg::PreambleByte);
    if (fault == FAULT_HEAD) begin
      send_byte(byte_other_than(fpr_pkg::PreambleByte, fpr_pkg::HeadByte));
      return;
    end
    send_byte(fpr_pkg::HeadByte);
    sum = fpr_pkg::HeadByte;
    keep = (fault == FAULT_CUT) ? $urandom_range(0, 2 + len) : 3 + len;
    for (int i = 0; i < keep; i++) begin
      d = (i == 0) ? addr : (i == 1) ? cmd : (i == 2) ? len : fpr_pkg::ByteW'($urandom);
      sum += d;
      send_byte(d);
    end
    if (fault == FAULT_CUT) return;
    if (fault == FAULT_SUM) begin
      send_byte(sum ^ (8'h01 << $urandom_range(0, 7)));
      return;
    end
    send_byte(sum);
    send_byte(fault == FAULT_TAIL ? byte_other_than(fpr_pkg::TailByte, fpr_pkg::TailByte)
                                  : fpr_pkg::TailByte);
  endtask

  task automatic wait_drained();
    while (rx_model.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    frame_fault_t fault;
    logic [fpr_pkg::ByteW-1:0] len;
    bit held, drained;
    held = 1'b0;
    drained = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle noise, bad head, repeated preamble, zero length, bad sum, bad tail
    send_byte(8'h00);
    send_byte(fpr_pkg::HeadByte);
    send_byte(fpr_pkg::PreambleByte);
    send_byte(8'h00);
    send_frame(3, 8'h00, 8'hFF, 8'h00, FAULT_NONE);
    send_frame(1, 8'hFF, 8'h00, 8'h01, FAULT_SUM);
    send_frame(1, 8'h00, 8'hFF, 8'h00, FAULT_TAIL);

    // Longest body reaches the highest field_index the parser gives, 257
    send_frame(1, fpr_pkg::ByteW'($urandom), fpr_pkg::ByteW'($urandom), 8'hFF, FAULT_NONE);

    while (bytes_sent < 600) begin
      if (!held && bytes_sent >= 350) begin
        held = 1'b1;
        gapless = 1'b1;
        hold_off_req = 1'b1;
        send_frame(1, fpr_pkg::ByteW'($urandom), fpr_pkg::ByteW'($urandom), 8'd24,
                   FAULT_NONE);
        gapless = 1'b0;
      end
      if (!drained && bytes_sent >= 480) begin
        drained = 1'b1;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        wait_drained();
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_byte(fpr_pkg::ByteW'($urandom));
      pick = $urandom_range(0, 99);
      fault = (pick < 70) ? FAULT_NONE : (pick < 77) ? FAULT_HEAD :
              (pick < 85) ? FAULT_SUM : (pick < 92) ? FAULT_TAIL : FAULT_CUT;
      len = ($urandom_range(0, 29) == 0) ? fpr_pkg::ByteW'($urandom_range(128, 255))
                                         : fpr_pkg::ByteW'($urandom_range(0, 8));
      send_frame($urandom_range(1, 3), fpr_pkg::ByteW'($urandom), fpr_pkg::ByteW'($urandom),
                 len, fault);
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d frames; checked %0d results (%0d body bytes).",
             bytes_sent, frames_sent, rx_model.n_checked, rx_model.n_fields);
    $display("Frames accepted %0d, rejected %0d; long output holds %0d, one full drain.",
             rx_model.n_accepted, rx_model.n_rejected, long_holds);
    if (rx_model.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
